@@ rtl/anchored_grid_quantizer_defines.svh @@
// Assertion macros for the anchored grid quantizer RTL.
`ifndef ANCHORED_GRID_QUANTIZER_DEFINES_SVH
`define ANCHORED_GRID_QUANTIZER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during rst.
`define AGQ_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("agq same-cycle check failed");
// Next-cycle implication, sampled on clk and disabled during rst.
`define AGQ_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("agq next-cycle check failed");
`else
`define AGQ_ASSERT_IMP(name, pre, post)
`define AGQ_ASSERT_NXT(name, pre, post)
`endif
`endif

@@ rtl/agq_pkg.sv @@
// Types and constants shared by the anchored grid quantizer modules.
`default_nettype none
package agq_pkg;

  // Internal arithmetic word, wide enough for a window edge plus a full width.
  localparam int DW = 28;
  typedef logic signed [DW-1:0] word_t;

  // Bin width register: reset value and lower bound, both 1.0 in Q15.8.
  localparam logic [22:0] WIDTH_RESET = 23'd256;
  localparam logic [22:0] WIDTH_MIN   = 23'd256;

  // Saturation limits of a bin value.
  localparam word_t BIN_MIN = -28'sd65536;
  localparam word_t BIN_MAX = 28'sd65535;

  // Rounding offsets for half away from zero with 8 and 9 fraction bits.
  localparam word_t RND8_POS = 28'sd128;
  localparam word_t RND8_NEG = 28'sd127;
  localparam word_t RND9_POS = 28'sd256;
  localparam word_t RND9_NEG = 28'sd255;

  // Request to the shared add and compare unit.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    logic  sub;
  } alu_req_t;

  // Response: the sum and whether c lies below it.
  typedef struct packed {
    word_t sum;
    logic  lt;
  } alu_rsp_t;

  // Sequencer states.
  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_ANC_RND  = 10'b00_0000_0010,
    S_ANC_LEFT = 10'b00_0000_0100,
    S_CHK_LO   = 10'b00_0000_1000,
    S_CHK_HI   = 10'b00_0001_0000,
    S_DOWN     = 10'b00_0010_0000,
    S_UP       = 10'b00_0100_0000,
    S_RND1     = 10'b00_1000_0000,
    S_RND2     = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

endpackage
`default_nettype wire

@@ rtl/anchored_grid_quantizer.sv @@
// Anchored grid quantizer: sequencer, state registers and output register.
// A run start or unanchored sample passes S_ANC_RND, S_ANC_LEFT and S_DONE; a sample
// in the window passes S_CHK_LO, S_CHK_HI and S_DONE; a move down passes S_CHK_LO
// and S_DOWN, a move up S_CHK_LO, S_CHK_HI and S_UP, stepping one width per cycle on
// the shared unit, then S_RND1, S_RND2 and S_DONE. One item at a time: input ready
// returns in the cycle after the result is loaded. Synchronous reset clears the
// sequencer, window state and output valid; the bin width register resets to 1.0.
`default_nettype none
`include "anchored_grid_quantizer_defines.svh"
module anchored_grid_quantizer
  import agq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [22:0] cfg_wdata,   // bin_width, unsigned Q15.8
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,     // [23:0] sample, signed Q16.8
  input  wire logic        s_tuser,     // [0] start_of_run
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata      // [16:0] bin, signed; [23:17] zero
);

  state_t state, state_next;

  logic [22:0]        bin_width;
  logic signed [23:0] sample;
  logic               start;
  logic               anchored;
  logic signed [25:0] left;
  word_t              right;
  word_t              center;
  logic signed [16:0] bin;

  logic [22:0] width_eff;
  word_t       half;
  word_t       wfull;
  word_t       s9;
  word_t       left_x;
  logic        s_accept;
  logic        slot_free;

  alu_req_t req;
  alu_rsp_t rsp;

  function automatic logic signed [16:0] sat_bin(input word_t v);
    word_t r;
    begin
      r = v;
      if (v < BIN_MIN) r = BIN_MIN;
      if (v > BIN_MAX) r = BIN_MAX;
      sat_bin = r[16:0];
    end
  endfunction

  // Effective width and derived operands in Q17.9.
  always_comb begin
    width_eff = (bin_width < WIDTH_MIN) ? WIDTH_MIN : bin_width;
    half      = {5'b0, width_eff};
    wfull     = {4'b0, width_eff, 1'b0};
    s9        = {{3{sample[23]}}, sample, 1'b0};
    left_x    = {{2{left[25]}}, left};
  end

  assign s_tready  = (state == S_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // Operand selection for the shared unit.
  always_comb begin
    req     = '0;
    req.c   = s9;
    case (state)
      S_ANC_RND: begin
        req.a = {{4{sample[23]}}, sample};
        req.b = sample[23] ? RND8_NEG : RND8_POS;
      end
      S_ANC_LEFT: begin
        req.a   = {{2{bin[16]}}, bin, 9'b0};
        req.b   = half;
        req.sub = 1'b1;
      end
      S_CHK_LO: begin
        req.a = left_x;
      end
      S_CHK_HI: begin
        req.a = left_x;
        req.b = wfull;
      end
      S_DOWN: begin
        req.a   = left_x;
        req.b   = wfull;
        req.sub = 1'b1;
      end
      S_UP: begin
        req.a = right;
        req.b = wfull;
      end
      S_RND1: begin
        req.a = left_x;
        req.b = half;
      end
      S_RND2: begin
        req.a = center;
        req.b = center[DW-1] ? RND9_NEG : RND9_POS;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  agq_alu u_alu (
    .req (req),
    .rsp (rsp)
  );

  // Sequencer transitions.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (s_accept) begin
                    state_next = (s_tuser || !anchored) ? S_ANC_RND : S_CHK_LO;
                  end
      S_ANC_RND:  state_next = S_ANC_LEFT;
      S_ANC_LEFT: state_next = S_DONE;
      S_CHK_LO:   state_next = rsp.lt ? S_DOWN : S_CHK_HI;
      S_CHK_HI:   state_next = rsp.lt ? S_DONE : S_UP;
      S_DOWN:     if (!rsp.lt) begin
                    state_next = S_RND1;
                  end
      S_UP:       if (rsp.lt) begin
                    state_next = S_RND1;
                  end
      S_RND1:     state_next = S_RND2;
      S_RND2:     state_next = S_DONE;
      S_DONE:     if (slot_free) begin
                    state_next = S_IDLE;
                  end
      default:    state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bin_width <= WIDTH_RESET;
      anchored  <= 1'b0;
      left      <= '0;
      bin       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        bin_width <= cfg_wdata;
      end
      if (state == S_ANC_RND) begin
        bin <= sat_bin(rsp.sum >>> 8);
      end
      if (state == S_RND2) begin
        bin <= sat_bin(rsp.sum >>> 9);
      end
      if (state == S_ANC_LEFT) begin
        left     <= rsp.sum[25:0];
        anchored <= 1'b1;
      end
      if (state == S_DOWN) begin
        left <= rsp.sum[25:0];
      end
      if (state == S_UP) begin
        left <= right[25:0];
      end
      if (state == S_DONE && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      sample <= s_tdata;
      start  <= s_tuser;
    end
    case (state)
      S_CHK_HI: right  <= rsp.sum;
      S_DOWN:   right  <= left_x;
      S_UP:     right  <= rsp.sum;
      S_RND1:   center <= rsp.sum;
      default:  ;
    endcase
    if (state == S_DONE && slot_free) begin
      m_tdata <= {7'b0, bin};
    end
  end

  // An accepted item always leaves idle on the next cycle.
  `AGQ_ASSERT_NXT(a_accept_leaves_idle, s_accept, state != S_IDLE)
  // A result is never produced before the grid has been anchored.
  `AGQ_ASSERT_IMP(a_done_anchored, state == S_DONE, anchored)
  // Once the window has stopped moving it holds the sample.
  `AGQ_ASSERT_IMP(a_window_holds, state == S_RND1, (s9 >= left_x) && (s9 < left_x + wfull))
  // A run start skips the window check path.
  `AGQ_ASSERT_IMP(a_start_anchors, state == S_CHK_LO, !start && anchored)
  // A finished item is loaded into the output register and the block returns to idle.
  `AGQ_ASSERT_NXT(a_done_loads, (state == S_DONE) && slot_free, m_tvalid && (state == S_IDLE))

endmodule
`default_nettype wire

@@ rtl/agq_alu.sv @@
// Shared add/subtract unit with a signed compare against its sum.
`default_nettype none
module agq_alu
  import agq_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  word_t sum;

  // One add or subtract, then compare the third operand against the result.
  always_comb begin
    sum     = req.sub ? (req.a - req.b) : (req.a + req.b);
    rsp.sum = sum;
    rsp.lt  = (req.c < sum);
  end

endmodule
`default_nettype wire

@@ verif/anchored_grid_quantizer_test.sv @@
// Self-checking testbench for the anchored grid quantizer: stream driver, monitor, bin predictor.
module anchored_grid_quantizer_test;
  import agq_pkg::*;

  // One sample item as it goes onto the input stream.
  typedef struct {
    logic [23:0] sample;
    logic        start;
  } sample_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [22:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // [23:0] sample, signed Q16.8
  logic        s_tuser = 1'b0;  // [0] start_of_run
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [16:0] bin, signed; [23:17] zero

  sample_item_t             pending_samples[$];
  logic signed [16:0]       expected_bins[$];
  int                       samples_sent = 0;
  int                       samples_taken = 0;
  int                       bins_taken = 0;
  int                       bins_seen = 0;
  int                       tx_wait = 0;
  int                       rx_stall = 0;
  int                       mismatch_count = 0;
  bit                       idle_on = 1'b1;

  // Predictor state: width register and the quantizer's window.
  logic [22:0]              grid_width = WIDTH_RESET;
  longint                   win_left = 0;
  longint                   cur_bin = 0;
  bit                       grid_anchored = 1'b0;

  anchored_grid_quantizer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Round a value with the given number of fraction bits half away from zero.
  function automatic longint round_half_away(longint v, int fb);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r = (mag + (longint'(1) <<< (fb - 1))) >>> fb;
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint clamp_bin(longint v);
    if (v < -65536) return -65536;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // Advance the window for one accepted sample and return the bin it maps to.
  function automatic logic signed [16:0] predict_bin(logic [23:0] raw, logic start);
    longint s8;
    longint s9;
    longint half;
    longint wfull;
    longint right;
    longint k;
    s8 = longint'($signed(raw));
    s9 = 2 * s8;
    // Widths under 1.0 act as 1.0; half a width in Q.9 is the raw register value.
    half = (grid_width < WIDTH_MIN) ? longint'(WIDTH_MIN) : longint'(grid_width);
    wfull = 2 * half;
    if (start || !grid_anchored) begin
      cur_bin = clamp_bin(round_half_away(s8, 8));
      win_left = cur_bin * 512 - half;
      grid_anchored = 1'b1;
    end else begin
      right = win_left + wfull;
      if (s9 < win_left) begin
        k = (win_left - s9 + wfull - 1) / wfull;
        win_left = win_left - k * wfull;
        cur_bin = clamp_bin(round_half_away(win_left + half, 9));
      end else if (s9 >= right) begin
        k = (s9 - right) / wfull + 1;
        win_left = win_left + k * wfull;
        cur_bin = clamp_bin(round_half_away(win_left + half, 9));
      end
    end
    return cur_bin[16:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch: %s, got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  // Input driver: draws a wait per item, then holds the item until it is taken.
  always @(negedge clk) begin
    if (!rst && !(s_tvalid && samples_taken != samples_sent)) begin
      if (s_tvalid) begin
        tx_wait = idle_on ? $urandom_range(0, 16) : 0;
      end
      if (tx_wait > 0) begin
        tx_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        s_tdata <= pending_samples[0].sample;
        s_tuser <= pending_samples[0].start;
        void'(pending_samples.pop_front());
        samples_sent++;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output side: after every accepted bin, drop ready for a drawn wait while idle_on is set.
  always @(negedge clk) begin
    if (!rst) begin
      if (bins_taken != bins_seen) begin
        bins_seen = bins_taken;
        rx_stall = idle_on ? $urandom_range(0, 16) : 0;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every accepted sample, check every accepted bin.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_bins.push_back(predict_bin(s_tdata, s_tuser));
        samples_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (expected_bins.size() == 0) begin
          report_mismatch("bin with no sample outstanding", m_tdata, 24'h0);
        end else begin
          if (m_tdata !== {7'b0, expected_bins[0]}) begin
            report_mismatch("bin", m_tdata, {7'b0, expected_bins[0]});
          end
          void'(expected_bins.pop_front());
        end
        bins_taken++;
      end
    end
  end

  // Hold until every queued sample is taken and every bin has come back.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || samples_taken != samples_sent ||
           expected_bins.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the width register while the block is idle.
  task automatic write_bin_width(input logic [22:0] w);
    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    grid_width = w;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_sample(input longint s, input logic start);
    sample_item_t it;
    it.sample = s[23:0];
    it.start = start;
    pending_samples.push_back(it);
  endtask

  function automatic longint full_range_sample();
    return longint'($urandom_range(0, 32'hFFFFFF)) - 64'sd8388608;
  endfunction

  // Mostly slow walks around the window, with run starts and farther jumps mixed in.
  task automatic queue_walk(input int n);
    longint span;
    longint pos;
    longint reach;
    int     pick;
    span = (grid_width < WIDTH_MIN) ? longint'(WIDTH_MIN) : longint'(grid_width);
    pos = full_range_sample();
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        pos = full_range_sample();
      end else if (pick < 14) begin
        // Far jumps over the whole range only where the width keeps the move short.
        if (span >= 65536) begin
          pos = full_range_sample();
        end else begin
          reach = 16 * span;
          pos = pos + longint'($urandom_range(0, 2 * reach)) - reach;
        end
      end else begin
        reach = (3 * span) / 2;
        pos = pos + longint'($urandom_range(0, 2 * reach)) - reach;
      end
      if (pos > 8388607) pos = 8388607;
      if (pos < -8388608) pos = -8388608;
      queue_sample(pos, pick < 6);
    end
  endtask

  initial begin
    logic [22:0] phase_widths[8];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset width of 1.0.
    queue_sample(0, 1'b0);          // first sample after reset anchors without the flag
    queue_sample(127, 1'b1);        // just under one half rounds to zero
    queue_sample(128, 1'b1);        // exact half rounds away from zero
    queue_sample(-128, 1'b1);
    queue_sample(-127, 1'b1);
    queue_sample(127, 1'b0);        // inside the window keeps the bin
    queue_sample(128, 1'b0);        // right edge moves up one width
    queue_sample(-129, 1'b0);       // below the window moves down two widths
    queue_sample(384, 1'b1);
    queue_sample(-384, 1'b1);
    queue_sample(8388607, 1'b1);    // largest sample
    queue_sample(-8388608, 1'b0);   // jump across the whole range in one item
    queue_sample(8388607, 1'b0);
    queue_sample(-8388608, 1'b1);   // smallest sample
    queue_sample(0, 1'b0);
    queue_sample(-1, 1'b0);
    queue_sample(255, 1'b0);

    // Each phase starts on the old window, so a new width takes over mid-run.
    phase_widths[0] = 23'd256;
    phase_widths[1] = 23'd0;
    phase_widths[2] = 23'h7FFFFF;
    phase_widths[3] = 23'd255;
    phase_widths[4] = 23'd65536;
    phase_widths[5] = 23'($urandom_range(256, 23'h7FFFFF));
    phase_widths[6] = 23'($urandom_range(256, 2048));
    phase_widths[7] = 23'd384;
    for (int p = 0; p < 8; p++) begin
      write_bin_width(phase_widths[p]);
      idle_on = (p % 3) != 2;
      queue_walk(92);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_bins.size() != 0) begin
      report_mismatch("bins never delivered", 24'(expected_bins.size()), 24'h0);
    end
    if (mismatch_count == 0) begin
      $display("anchored_grid_quantizer_test OK");
    end else begin
      $display("anchored_grid_quantizer_test NOT OK");
    end
    $finish;
  end

  // Run limit, well above the slowest legal run including the full-range jumps.
  initial begin
    #8000000;
    $display("anchored_grid_quantizer_test NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/agq_pkg.sv
rtl/agq_alu.sv
rtl/anchored_grid_quantizer.sv
verif/anchored_grid_quantizer_test.sv
